@@ rtl/utf8_to_fibonacci_encoder_defines.svh @@
// Assertion helpers used by the encoder RTL.
`ifndef UTF8_TO_FIBONACCI_ENCODER_DEFINES_SVH
`define UTF8_TO_FIBONACCI_ENCODER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define U2F_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("u2f: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define U2F_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("u2f: next-cycle check failed");

`endif

@@ rtl/u2f_pkg.sv @@
package u2f_pkg;

    localparam int CP_W      = 21;
    localparam int FIB_COUNT = 29;
    localparam int FIB_W     = 20;
    localparam int IDX_W     = 5;

    localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(FIB_COUNT - 1);
    localparam logic [CP_W-1:0]  CP_MAX  = CP_W'(1114111);

    typedef enum logic [2:0] {
        ERR_NONE  = 3'd0,
        ERR_LEAD  = 3'd1,
        ERR_CONT  = 3'd2,
        ERR_TRUNC = 3'd3,
        ERR_RANGE = 3'd4
    } err_code_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_stream;
    } utf_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic [2:0] error_code;
        logic       last;
    } code_item_t;

    // One code bit offered by the Zeckendorf unit to the packer.
    typedef struct packed {
        logic valid;
        logic code_bit;
        logic last_bit;
        logic few_left;
    } zk_bit_t;

    function automatic logic [FIB_W-1:0] fib_term(input logic [IDX_W-1:0] idx);
        logic [FIB_W-1:0] term;
        case (idx)
            5'd0:    term = 20'd1;
            5'd1:    term = 20'd2;
            5'd2:    term = 20'd3;
            5'd3:    term = 20'd5;
            5'd4:    term = 20'd8;
            5'd5:    term = 20'd13;
            5'd6:    term = 20'd21;
            5'd7:    term = 20'd34;
            5'd8:    term = 20'd55;
            5'd9:    term = 20'd89;
            5'd10:   term = 20'd144;
            5'd11:   term = 20'd233;
            5'd12:   term = 20'd377;
            5'd13:   term = 20'd610;
            5'd14:   term = 20'd987;
            5'd15:   term = 20'd1597;
            5'd16:   term = 20'd2584;
            5'd17:   term = 20'd4181;
            5'd18:   term = 20'd6765;
            5'd19:   term = 20'd10946;
            5'd20:   term = 20'd17711;
            5'd21:   term = 20'd28657;
            5'd22:   term = 20'd46368;
            5'd23:   term = 20'd75025;
            5'd24:   term = 20'd121393;
            5'd25:   term = 20'd196418;
            5'd26:   term = 20'd317811;
            5'd27:   term = 20'd514229;
            5'd28:   term = 20'd832040;
            default: term = 20'hFFFFF;
        endcase
        return term;
    endfunction

endpackage

@@ rtl/u2f_zeck.sv @@
module u2f_zeck
    import u2f_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [CP_W-1:0] start_value,
    input  logic            hold,
    output zk_bit_t         bit_out,
    output logic            busy
);

    typedef enum logic [2:0] {
        ZK_IDLE = 3'b001,
        ZK_SCAN = 3'b010,
        ZK_EMIT = 3'b100
    } zk_state_t;

    zk_state_t              state_reg, state_next;
    logic [CP_W-1:0]        rest_reg, rest_next;
    logic [IDX_W-1:0]       term_idx_reg, term_idx_next;
    logic [FIB_COUNT-1:0]   digits_reg, digits_next;
    logic [IDX_W-1:0]       bits_left_reg, bits_left_next;
    logic [FIB_W-1:0]       term;
    logic                   take;

    assign term = fib_term(term_idx_reg);
    assign take = (rest_reg >= {1'b0, term});

    always_comb
    begin
        state_next     = state_reg;
        rest_next      = rest_reg;
        term_idx_next  = term_idx_reg;
        digits_next    = digits_reg;
        bits_left_next = bits_left_reg;
        case (state_reg)
            ZK_IDLE:
            begin
                if (start)
                begin
                    rest_next     = start_value;
                    term_idx_next = TOP_IDX;
                    digits_next   = '0;
                    state_next    = ZK_SCAN;
                end
            end
            ZK_SCAN:
            begin
                // greedy, top term first; digit j lands at bit j after the last step
                digits_next = {digits_reg[FIB_COUNT-2:0], take};
                if (take)
                begin
                    rest_next = rest_reg - {1'b0, term};
                    // first term taken is the top one: code length is top + 1 plus closer
                    if (digits_reg == '0)
                        bits_left_next = term_idx_reg + IDX_W'(2);
                end
                if (term_idx_reg == '0)
                    state_next = ZK_EMIT;
                else
                    term_idx_next = term_idx_reg - IDX_W'(1);
            end
            ZK_EMIT:
            begin
                if (!hold)
                begin
                    digits_next    = digits_reg >> 1;
                    bits_left_next = bits_left_reg - IDX_W'(1);
                    if (bits_left_reg == IDX_W'(1))
                        state_next = ZK_IDLE;
                end
            end
            default:
            begin
                state_next = ZK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        bit_out.valid    = (state_reg == ZK_EMIT);
        bit_out.last_bit = (bits_left_reg == IDX_W'(1));
        bit_out.code_bit = bit_out.last_bit | digits_reg[0];
        bit_out.few_left = (bits_left_reg <= IDX_W'(8));
    end

    assign busy = (state_reg != ZK_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ZK_IDLE;
            term_idx_reg  <= '0;
            bits_left_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            term_idx_reg  <= term_idx_next;
            bits_left_reg <= bits_left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rest_reg   <= rest_next;
        digits_reg <= digits_next;
    end

endmodule

@@ rtl/utf8_to_fibonacci_encoder.sv @@
// A byte that completes no character has its result in the output register in the
// cycle after acceptance. A completed character is first scanned bit-serially by the
// Zeckendorf unit over 29 Fibonacci terms, then emitted one bit per cycle into the
// byte packer while the output does not stall that emission.
// Throughput: other items one per cycle while the output drains and the Zeckendorf unit is idle.
// Reset: asynchronous, active low; clears decoder, packer and the sticky error.
`include "utf8_to_fibonacci_encoder_defines.svh"

module utf8_to_fibonacci_encoder
    import u2f_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       utf_valid,
    output logic       utf_stall,
    input  utf_item_t  utf_data,
    output logic       code_valid,
    input  logic       code_stall,
    output code_item_t code_data
);

    code_item_t       out_reg, out_next;
    logic             out_valid_reg, out_valid_next;
    logic [CP_W-1:0]  code_accum_reg, code_accum_next;
    logic [1:0]       cont_left_reg, cont_left_next;
    logic [7:0]       pack_byte_reg, pack_byte_next;
    logic [2:0]       pack_count_reg, pack_count_next;
    err_code_t        error_reg, error_next;
    logic             produced_reg, produced_next;

    logic             out_free;
    logic             accept;
    logic             push;
    logic             hold;
    logic             zk_start;
    logic [CP_W-1:0]  zk_value;
    logic             zk_busy;
    zk_bit_t          zk_bit;
    logic             wr_dummy;
    logic [CP_W-1:0]  cp_next;
    logic [7:0]       pack_merged;

    u2f_zeck u_zeck (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (zk_start),
        .start_value (zk_value),
        .hold        (hold),
        .bit_out     (zk_bit),
        .busy        (zk_busy)
    );

    assign out_free  = !out_valid_reg || !code_stall;
    assign utf_stall = zk_busy || !out_free;
    assign accept    = utf_valid && !utf_stall;

    // stall the bit stream where it fills a byte or ends a character while the output cannot take a result
    assign hold = zk_bit.valid && !out_free
                  && ((pack_count_reg == 3'd7) || zk_bit.last_bit);
    assign push = zk_bit.valid && !hold;

    assign cp_next     = {code_accum_reg[CP_W-7:0], utf_data.in_byte[5:0]};
    assign pack_merged = pack_byte_reg | (8'(zk_bit.code_bit) << pack_count_reg);

    always_comb
    begin
        out_next        = out_reg;
        code_accum_next = code_accum_reg;
        cont_left_next  = cont_left_reg;
        pack_byte_next  = pack_byte_reg;
        pack_count_next = pack_count_reg;
        error_next      = error_reg;
        produced_next   = produced_reg;
        zk_start        = 1'b0;
        zk_value        = CP_W'(utf_data.in_byte) + CP_W'(1);
        wr_dummy        = 1'b0;
        out_valid_next  = out_valid_reg && code_stall;

        if (accept)
        begin
            if (error_reg != ERR_NONE)
            begin
                wr_dummy = 1'b1;
            end
            else if (utf_data.end_of_stream)
            begin
                if (cont_left_reg != 2'd0)
                begin
                    error_next = ERR_TRUNC;
                    wr_dummy   = 1'b1;
                end
                else
                begin
                    if ((pack_count_reg != 3'd0) && (pack_byte_reg != 8'd0))
                    begin
                        out_next.out_byte   = pack_byte_reg;
                        out_next.byte_valid = 1'b1;
                        out_next.error_code = ERR_NONE;
                        out_next.last       = 1'b1;
                        out_valid_next      = 1'b1;
                    end
                    else
                    begin
                        wr_dummy = 1'b1;
                    end
                    pack_byte_next  = '0;
                    pack_count_next = '0;
                    code_accum_next = '0;
                end
            end
            else if (cont_left_reg == 2'd0)
            begin
                if (!utf_data.in_byte[7])
                begin
                    zk_start      = 1'b1;
                    produced_next = 1'b0;
                end
                else if (utf_data.in_byte[7:5] == 3'b110)
                begin
                    code_accum_next = CP_W'(utf_data.in_byte[4:0]);
                    cont_left_next  = 2'd1;
                    wr_dummy        = 1'b1;
                end
                else if (utf_data.in_byte[7:4] == 4'b1110)
                begin
                    code_accum_next = CP_W'(utf_data.in_byte[3:0]);
                    cont_left_next  = 2'd2;
                    wr_dummy        = 1'b1;
                end
                else if (utf_data.in_byte[7:3] == 5'b11110)
                begin
                    code_accum_next = CP_W'(utf_data.in_byte[2:0]);
                    cont_left_next  = 2'd3;
                    wr_dummy        = 1'b1;
                end
                else
                begin
                    error_next = ERR_LEAD;
                    wr_dummy   = 1'b1;
                end
            end
            else
            begin
                if (utf_data.in_byte[7:6] != 2'b10)
                begin
                    error_next = ERR_CONT;
                    wr_dummy   = 1'b1;
                end
                else
                begin
                    code_accum_next = cp_next;
                    cont_left_next  = cont_left_reg - 2'd1;
                    if (cont_left_reg != 2'd1)
                    begin
                        wr_dummy = 1'b1;
                    end
                    else if (cp_next > CP_MAX)
                    begin
                        error_next = ERR_RANGE;
                        wr_dummy   = 1'b1;
                    end
                    else
                    begin
                        zk_value      = cp_next + CP_W'(1);
                        zk_start      = 1'b1;
                        produced_next = 1'b0;
                    end
                end
            end
        end

        if (push)
        begin
            if (pack_count_reg == 3'd7)
            begin
                out_next.out_byte   = pack_merged;
                out_next.byte_valid = 1'b1;
                out_next.error_code = error_reg;
                out_next.last       = zk_bit.few_left;
                out_valid_next      = 1'b1;
                produced_next       = 1'b1;
                pack_byte_next      = '0;
                pack_count_next     = '0;
            end
            else
            begin
                pack_byte_next  = pack_merged;
                pack_count_next = pack_count_reg + 3'd1;
                // character finished without filling a byte
                if (zk_bit.last_bit && !produced_reg)
                    wr_dummy = 1'b1;
            end
        end

        if (wr_dummy)
        begin
            out_next.out_byte   = '0;
            out_next.byte_valid = 1'b0;
            out_next.error_code = error_next;
            out_next.last       = 1'b1;
            out_valid_next      = 1'b1;
        end
    end

    assign code_valid = out_valid_reg;
    assign code_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            code_accum_reg <= '0;
            cont_left_reg  <= '0;
            pack_byte_reg  <= '0;
            pack_count_reg <= '0;
            error_reg      <= ERR_NONE;
            produced_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            code_accum_reg <= code_accum_next;
            cont_left_reg  <= cont_left_next;
            pack_byte_reg  <= pack_byte_next;
            pack_count_reg <= pack_count_next;
            error_reg      <= error_next;
            produced_reg   <= produced_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    `U2F_ASSERT_NOW(a_busy_stalls, zk_busy, utf_stall)
    `U2F_ASSERT_NEXT(a_start_busy, zk_start, zk_busy)
    `U2F_ASSERT_NEXT(a_error_sticky, error_reg != ERR_NONE, $stable(error_reg))
    `U2F_ASSERT_NOW(a_no_byte_after_error, (error_reg != ERR_NONE) && out_valid_reg, !out_reg.byte_valid)

endmodule
